// ===== rtl/pfd_pkg.sv =====
// shared types and constants for the playfair pair decrypt core
// no dependencies
`default_nettype none

package pfd_pkg;

    localparam int SIDE       = 5;
    localparam int CODE_W     = 5;
    localparam int POS_W      = 3;
    localparam int HALF_CELLS = 12;
    localparam int HALF_W     = HALF_CELLS * CODE_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CODE_W-1:0] CODE_I = 5'd8;
    localparam logic [CODE_W-1:0] CODE_J = 5'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_LAST  = 2'd2;

    typedef logic [SIDE-1:0][SIDE-1:0][CODE_W-1:0] square_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } loc_t;

endpackage

`default_nettype wire

// ===== rtl/pfd_lane.sv =====
// one search lane: locates a letter code in the key square, first match row-major
// depends on pfd_pkg
`default_nettype none

module pfd_lane (
    input  wire logic [pfd_pkg::CODE_W-1:0] code,
    input  wire pfd_pkg::square_t           square,
    output pfd_pkg::loc_t                   loc
);
    import pfd_pkg::*;

    logic [CODE_W-1:0] key;

    assign key = (code == CODE_J) ? CODE_I : code;

    // scan from the last cell back so the earliest match wins
    always_comb
    begin
        loc = '0;
        for (int r = SIDE - 1; r >= 0; r--)
        begin
            for (int c = SIDE - 1; c >= 0; c--)
            begin
                if (square[r][c] == key)
                begin
                    loc.found = 1'b1;
                    loc.row   = POS_W'(r);
                    loc.col   = POS_W'(c);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfd_merge.sv =====
// merge stage: applies the row, column and rectangle rules to both lane results
// depends on pfd_pkg
`default_nettype none

module pfd_merge (
    input  wire pfd_pkg::loc_t              loc_first,
    input  wire pfd_pkg::loc_t              loc_second,
    input  wire pfd_pkg::square_t           square,
    output logic [pfd_pkg::CODE_W-1:0]      plain_first,
    output logic [pfd_pkg::CODE_W-1:0]      plain_second,
    output logic                            letter_missing
);
    import pfd_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(SIDE - 1);

    logic [POS_W-1:0] row_a;
    logic [POS_W-1:0] col_a;
    logic [POS_W-1:0] row_b;
    logic [POS_W-1:0] col_b;

    function automatic logic [POS_W-1:0] step_back(input logic [POS_W-1:0] p);
        step_back = (p == '0) ? LAST_POS : p - POS_W'(1);
    endfunction

    always_comb
    begin
        row_a = loc_first.row;
        col_a = loc_first.col;
        row_b = loc_second.row;
        col_b = loc_second.col;
        if (loc_first.row == loc_second.row)
        begin
            col_a = step_back(loc_first.col);
            col_b = step_back(loc_second.col);
        end
        else if (loc_first.col == loc_second.col)
        begin
            row_a = step_back(loc_first.row);
            row_b = step_back(loc_second.row);
        end
        else
        begin
            col_a = loc_second.col;
            col_b = loc_first.col;
        end
    end

    always_comb
    begin
        letter_missing = !(loc_first.found && loc_second.found);
        if (letter_missing)
        begin
            plain_first  = '0;
            plain_second = '0;
        end
        else
        begin
            plain_first  = square[row_a][col_a];
            plain_second = square[row_b][col_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/playfair_pair_decrypt_core.sv =====
// top level of the playfair pair decrypt core: key square registers, two search
// lanes and the merge stage; depends on pfd_pkg, pfd_lane, pfd_merge
//
//  channel   signals                                       direction
//  request   start, busy, cipher_first, cipher_second      in (busy out)
//  result    done, plain_first, plain_second,              out
//            letter_missing
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data     in (cfg_ready out)
//
// one request per cycle; each result is registered after the lane search and again after the merge
// two register stages: lane search, then merge and cell select
// busy and cfg_ready stay low and high; the receiver cannot stall
// reset clears the key square to zero and all pipeline valid flags
`default_nettype none

module playfair_pair_decrypt_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pfd_pkg::CODE_W-1:0]    cipher_first,
    input  wire logic [pfd_pkg::CODE_W-1:0]    cipher_second,
    output logic                               done,
    output logic [pfd_pkg::CODE_W-1:0]         plain_first,
    output logic [pfd_pkg::CODE_W-1:0]         plain_second,
    output logic                               letter_missing,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pfd_pkg::HALF_W-1:0]    cfg_data
);
    import pfd_pkg::*;

    logic [HALF_W-1:0] cells_low_reg;
    logic [HALF_W-1:0] cells_high_reg;
    logic [CODE_W-1:0] cell_last_reg;
    square_t           square;

    logic              valid1_reg;
    loc_t              loc_first_reg;
    loc_t              loc_second_reg;
    loc_t              loc_first_next;
    loc_t              loc_second_next;

    logic              done_reg;
    logic [CODE_W-1:0] plain_first_reg;
    logic [CODE_W-1:0] plain_second_reg;
    logic              missing_reg;
    logic [CODE_W-1:0] plain_first_next;
    logic [CODE_W-1:0] plain_second_next;
    logic              missing_next;

    logic              accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_low_reg  <= '0;
            cells_high_reg <= '0;
            cell_last_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CELLS_LOW:  cells_low_reg  <= cfg_data;
                CFG_CELLS_HIGH: cells_high_reg <= cfg_data;
                CFG_CELL_LAST:  cell_last_reg  <= cfg_data[CODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (r * SIDE + c < HALF_CELLS)
                    square[r][c] = cells_low_reg[(r * SIDE + c) * CODE_W +: CODE_W];
                else if (r * SIDE + c < 2 * HALF_CELLS)
                    square[r][c] =
                        cells_high_reg[(r * SIDE + c - HALF_CELLS) * CODE_W +: CODE_W];
                else
                    square[r][c] = cell_last_reg;
            end
        end
    end

    pfd_lane u_lane_first (
        .code   (cipher_first),
        .square (square),
        .loc    (loc_first_next)
    );

    pfd_lane u_lane_second (
        .code   (cipher_second),
        .square (square),
        .loc    (loc_second_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= accept;
            done_reg   <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            loc_first_reg  <= loc_first_next;
            loc_second_reg <= loc_second_next;
        end
        if (valid1_reg)
        begin
            plain_first_reg  <= plain_first_next;
            plain_second_reg <= plain_second_next;
            missing_reg      <= missing_next;
        end
    end

    pfd_merge u_merge (
        .loc_first      (loc_first_reg),
        .loc_second     (loc_second_reg),
        .square         (square),
        .plain_first    (plain_first_next),
        .plain_second   (plain_second_next),
        .letter_missing (missing_next)
    );

    assign done           = done_reg;
    assign plain_first    = plain_first_reg;
    assign plain_second   = plain_second_reg;
    assign letter_missing = missing_reg;

endmodule

`default_nettype wire
